@@ src/ocss_pkg.sv @@
// ocss_pkg: shared types and constants of the obstacle cone and sphere scan
// no dependencies; imported by the result and config interfaces, ocss_front, ocss_back and the top level

package ocss_pkg;

    // fixed field widths
    localparam int FWD_W       = 23;
    localparam int SIDE_W      = 16;
    localparam int CFG_W       = 16;
    localparam int CFG_INDEX_W = 2;

    // scan limits, 1/1024 m
    localparam int FWD_MIN     = 102;
    localparam int BELOW_LIMIT = 205;

    localparam logic [FWD_W-1:0]  FWD_SAT  = '1;
    localparam logic [SIDE_W-1:0] SIDE_INF = '1;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_CONE_BASE   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CONE_SLOPE  = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SIDE_RADIUS = 2'd2;

    localparam logic [CFG_W-1:0] CONE_BASE_RESET   = 16'd512;
    localparam logic [CFG_W-1:0] CONE_SLOPE_RESET  = 16'd4096;
    localparam logic [CFG_W-1:0] SIDE_RADIUS_RESET = 16'd1024;

    localparam logic signed [15:0] HEADING_COS_RESET = 16'sd16384;

    // input queue between front and back
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = 2;

    typedef enum logic [1:0] {
        KIND_POSE,
        KIND_POSE_LAST,
        KIND_POINT,
        KIND_POINT_LAST
    } item_kind_t;

    typedef enum logic [1:0] {
        BK_RUN,
        BK_DRAIN,
        BK_ROOT,
        BK_EMIT
    } back_state_t;

    typedef struct packed {
        logic [CFG_W-1:0] cone_base_radius;
        logic [CFG_W-1:0] cone_slope;
        logic [CFG_W-1:0] side_radius;
    } cfg_t;

endpackage

@@ src/ocss_if.sv @@
// ocss_if: valid/ready channel interfaces of the scan block (items, results, config)
// depends on ocss_pkg for field widths

interface ocss_in_if #(
    parameter int COORD_WIDTH = 24
);
    logic                          valid;
    logic                          ready;
    logic                          action;
    logic signed [COORD_WIDTH-1:0] coord_x;
    logic signed [COORD_WIDTH-1:0] coord_y;
    logic signed [COORD_WIDTH-1:0] coord_z;
    logic signed [15:0]            heading_cos;
    logic signed [15:0]            heading_sin;
    logic                          last;

    modport source (
        output valid, action, coord_x, coord_y, coord_z, heading_cos, heading_sin, last,
        input  ready
    );
    modport sink (
        input  valid, action, coord_x, coord_y, coord_z, heading_cos, heading_sin, last,
        output ready
    );
endinterface

interface ocss_out_if import ocss_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [FWD_W-1:0]  forward_distance;
    logic              forward_found;
    logic [SIDE_W-1:0] side_distance;
    logic              side_found;

    modport source (
        output valid, forward_distance, forward_found, side_distance, side_found,
        input  ready
    );
    modport sink (
        input  valid, forward_distance, forward_found, side_distance, side_found,
        output ready
    );
endinterface

interface ocss_cfg_if import ocss_pkg::*; ();
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_W-1:0]       data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

@@ src/ocss_front.sv @@
// ocss_front: accepts item words, classifies them as pose or point, queues them for the back
// depends on ocss_pkg and ocss_in_if

module ocss_front
    import ocss_pkg::*;
#(
    parameter int COORD_WIDTH = 24
)(
    input  logic                          clk,
    input  logic                          rst_n,
    ocss_in_if.sink                       item,
    output logic                          head_valid,
    output item_kind_t                    head_kind,
    output logic signed [COORD_WIDTH-1:0] head_x,
    output logic signed [COORD_WIDTH-1:0] head_y,
    output logic signed [COORD_WIDTH-1:0] head_z,
    output logic signed [15:0]            head_cos,
    output logic signed [15:0]            head_sin,
    input  logic                          head_pop
);

    item_kind_t                    kind_reg [FIFO_DEPTH];
    logic signed [COORD_WIDTH-1:0] x_reg    [FIFO_DEPTH];
    logic signed [COORD_WIDTH-1:0] y_reg    [FIFO_DEPTH];
    logic signed [COORD_WIDTH-1:0] z_reg    [FIFO_DEPTH];
    logic signed [15:0]            cos_reg  [FIFO_DEPTH];
    logic signed [15:0]            sin_reg  [FIFO_DEPTH];

    logic [FIFO_AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_AW:0]   count_reg, count_next;
    logic               push;
    logic               pop;
    item_kind_t         kind_in;

    assign item.ready = (count_reg != (FIFO_AW+1)'(FIFO_DEPTH));
    assign push       = item.valid && item.ready;
    assign pop        = head_pop && head_valid;

    always_comb
    begin
        if (item.action)
            kind_in = item.last ? KIND_POINT_LAST : KIND_POINT;
        else
            kind_in = item.last ? KIND_POSE_LAST : KIND_POSE;
    end

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            kind_reg[wr_ptr_reg] <= kind_in;
            x_reg[wr_ptr_reg]    <= item.coord_x;
            y_reg[wr_ptr_reg]    <= item.coord_y;
            z_reg[wr_ptr_reg]    <= item.coord_z;
            cos_reg[wr_ptr_reg]  <= item.heading_cos;
            sin_reg[wr_ptr_reg]  <= item.heading_sin;
        end
    end

    assign head_valid = (count_reg != '0);
    assign head_kind  = kind_reg[rd_ptr_reg];
    assign head_x     = x_reg[rd_ptr_reg];
    assign head_y     = y_reg[rd_ptr_reg];
    assign head_z     = z_reg[rd_ptr_reg];
    assign head_cos   = cos_reg[rd_ptr_reg];
    assign head_sin   = sin_reg[rd_ptr_reg];

endmodule

@@ src/ocss_square.sv @@
// ocss_square: two-stage squarer, operand split in halves so each partial product stays narrow
// no dependencies; used by ocss_back for the cone test

module ocss_square #(
    parameter int N = 24
)(
    input  logic           clk,
    input  logic [N-1:0]   a,
    output logic [2*N-1:0] sq
);

    localparam int H = (N + 1) / 2;
    localparam int L = N - H;

    logic [2*H-1:0] ll_reg;
    logic [N-1:0]   hl_reg;
    logic [2*L-1:0] hh_reg;
    logic [2*N-1:0] sq_reg;

    always_ff @(posedge clk)
    begin
        ll_reg <= a[H-1:0] * a[H-1:0];
        hl_reg <= a[N-1:H] * a[H-1:0];
        hh_reg <= a[N-1:H] * a[N-1:H];
        // a^2 = hh*2^2H + 2*hl*2^H + ll
        sq_reg <= ((2*N)'(hh_reg) << (2*H)) + ((2*N)'(hl_reg) << (H+1)) + (2*N)'(ll_reg);
    end

    assign sq = sq_reg;

endmodule

@@ src/ocss_isqrt.sv @@
// ocss_isqrt: floor square root of a 32-bit value, one result bit per cycle
// no dependencies; used by ocss_back for the side distance

module ocss_isqrt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [31:0] operand,
    output logic        busy,
    output logic [15:0] root
);

    logic [31:0] rem_reg, rem_next;
    logic [31:0] res_reg, res_next;
    logic [31:0] bit_reg, bit_next;
    logic [31:0] trial;

    assign trial = res_reg + bit_reg;

    always_comb
    begin
        rem_next = rem_reg;
        res_next = res_reg;
        bit_next = bit_reg;
        if (start)
        begin
            rem_next = operand;
            res_next = '0;
            bit_next = 32'h4000_0000;
        end
        else if (bit_reg != '0)
        begin
            if (rem_reg >= trial)
            begin
                rem_next = rem_reg - trial;
                res_next = (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            bit_reg <= '0;
        else
            bit_reg <= bit_next;
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        res_reg <= res_next;
    end

    // the one-hot trial bit doubles as the step counter
    assign busy = (bit_reg != '0);
    assign root = res_reg[15:0];

endmodule

@@ src/ocss_back.sv @@
// ocss_back: point pipeline (rotate, cone and sphere tests, minima), pose load, result root
// depends on ocss_pkg, ocss_out_if, ocss_square and ocss_isqrt

module ocss_back
    import ocss_pkg::*;
#(
    parameter int COORD_WIDTH = 24
)(
    input  logic                          clk,
    input  logic                          rst_n,
    input  cfg_t                          cfg,
    input  logic                          head_valid,
    input  item_kind_t                    head_kind,
    input  logic signed [COORD_WIDTH-1:0] head_x,
    input  logic signed [COORD_WIDTH-1:0] head_y,
    input  logic signed [COORD_WIDTH-1:0] head_z,
    input  logic signed [15:0]            head_cos,
    input  logic signed [15:0]            head_sin,
    output logic                          head_pop,
    ocss_out_if.source                    result
);

    localparam int RW         = COORD_WIDTH + 1;   // relative coordinate
    localparam int PW         = COORD_WIDTH + 17;  // heading product
    localparam int XW         = COORD_WIDTH + 4;   // rotated coordinate
    localparam int MW         = COORD_WIDTH + 3;   // lateral magnitude
    localparam int FPW        = MW + 16;           // depth times slope
    localparam int RMW        = COORD_WIDTH + 7;   // cone radius
    localparam int SW         = (XW > 24) ? XW : 24;
    localparam int PIPE_DEPTH = 7;

    // pose and heading
    logic signed [COORD_WIDTH-1:0] pose_x_reg, pose_y_reg, pose_z_reg;
    logic signed [15:0]            heading_cos_reg, heading_sin_reg;

    // minima
    logic [23:0] best_forward_reg, best_forward_next;
    logic        forward_hit_reg, forward_hit_next;
    logic [31:0] best_side_square_reg, best_side_square_next;
    logic        side_hit_reg, side_hit_next;
    logic [31:0] side_sq_reg;

    back_state_t state_reg, state_next;
    logic [PIPE_DEPTH-1:0] pipe_v_reg, pipe_v_next;

    logic is_point, is_last, pipe_empty, out_free;
    logic issue, pose_load, sqrt_start, out_load;
    logic sqrt_busy;
    logic [15:0] sqrt_root;

    // stage 1
    logic signed [RW-1:0] s1_rx_reg, s1_ry_reg, s1_rz_reg;
    // stage 2
    logic signed [PW-1:0] s2_cx_reg, s2_sy_reg, s2_cy_reg, s2_sx_reg;
    logic [COORD_WIDTH-1:0] s2_mx_reg, s2_my_reg, s2_mz_reg;
    logic s2_below_reg;
    // stage 3
    logic signed [XW-1:0] s3_xf_reg, s3_yf_reg;
    logic [31:0] s3_sqx_reg, s3_sqy_reg, s3_sqz_reg;
    logic s3_near_reg;
    logic [COORD_WIDTH-1:0] s3_mz_reg;
    // stage 4
    logic [FPW-1:0] s4_fprod_reg;
    logic s4_ahead_reg, s4_side_ok_reg;
    logic [FWD_W-1:0] s4_xf_sat_reg;
    logic [MW-1:0] s4_yfm_reg;
    logic [COORD_WIDTH-1:0] s4_mz_reg;
    logic [31:0] s4_d2_reg;
    // stage 5
    logic [RMW-1:0] s5_rmax_reg;
    logic [MW-1:0] s5_yfm_reg;
    logic [COORD_WIDTH-1:0] s5_mz_reg;
    logic s5_ahead_reg, s5_side_ok_reg;
    logic [FWD_W-1:0] s5_xf_sat_reg;
    logic [31:0] s5_d2_reg;
    // stages 6 and 7, beside the squarers
    logic s6_ahead_reg, s6_side_ok_reg, s7_ahead_reg, s7_side_ok_reg;
    logic [FWD_W-1:0] s6_xf_sat_reg, s7_xf_sat_reg;
    logic [31:0] s6_d2_reg, s7_d2_reg;

    logic signed [RW-1:0] nrx, nry, nrz;
    logic signed [PW:0]   sum_f, sum_l;
    logic signed [SW-1:0] xf_ext;
    logic signed [XW-1:0] nyf;
    logic [33:0]          d2;
    logic [2*MW-1:0]      ysq;
    logic [2*COORD_WIDTH-1:0] zsq;
    logic [2*RMW-1:0]     rsq;
    logic [2*RMW-1:0]     lat;
    logic                 cone_ok;

    // ---- control ----
    assign is_point   = head_kind inside {KIND_POINT, KIND_POINT_LAST};
    assign is_last    = head_kind inside {KIND_POSE_LAST, KIND_POINT_LAST};
    assign pipe_empty = (pipe_v_reg == '0);
    assign out_free   = !result.valid || result.ready;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_RUN:
            begin
                if (head_valid && (is_point || pipe_empty) && is_last)
                    state_next = BK_DRAIN;
            end
            BK_DRAIN:
            begin
                if (pipe_empty)
                    state_next = BK_ROOT;
            end
            BK_ROOT:
            begin
                if (!sqrt_busy)
                    state_next = BK_EMIT;
            end
            BK_EMIT:
            begin
                if (out_free)
                    state_next = BK_RUN;
            end
            default:
            begin
                state_next = BK_RUN;
            end
        endcase
    end

    always_comb
    begin
        head_pop   = 1'b0;
        issue      = 1'b0;
        pose_load  = 1'b0;
        sqrt_start = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            BK_RUN:
            begin
                if (head_valid)
                begin
                    if (is_point)
                    begin
                        head_pop = 1'b1;
                        issue    = 1'b1;
                    end
                    else if (pipe_empty)
                    begin
                        // a pose waits until every earlier point has updated the minima
                        head_pop  = 1'b1;
                        pose_load = 1'b1;
                    end
                end
            end
            BK_DRAIN:
            begin
                sqrt_start = pipe_empty;
            end
            BK_ROOT:
            begin
                sqrt_start = 1'b0;
            end
            BK_EMIT:
            begin
                out_load = out_free;
            end
            default:
            begin
                head_pop = 1'b0;
            end
        endcase
    end

    assign pipe_v_next = {pipe_v_reg[PIPE_DEPTH-2:0], issue};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= BK_RUN;
            pipe_v_reg <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            pipe_v_reg <= pipe_v_next;
        end
    end

    // ---- pose ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pose_x_reg      <= '0;
            pose_y_reg      <= '0;
            pose_z_reg      <= '0;
            heading_cos_reg <= HEADING_COS_RESET;
            heading_sin_reg <= '0;
        end
        else if (pose_load)
        begin
            pose_x_reg      <= head_x;
            pose_y_reg      <= head_y;
            pose_z_reg      <= head_z;
            heading_cos_reg <= head_cos;
            heading_sin_reg <= head_sin;
        end
    end

    // ---- point pipeline ----
    assign nrx = -s1_rx_reg;
    assign nry = -s1_ry_reg;
    assign nrz = -s1_rz_reg;

    assign sum_f = (PW+1)'(s2_cx_reg) + (PW+1)'(s2_sy_reg);
    assign sum_l = (PW+1)'(s2_cy_reg) - (PW+1)'(s2_sx_reg);

    assign xf_ext = SW'(s3_xf_reg);
    assign nyf    = -s3_yf_reg;
    assign d2     = 34'(s3_sqx_reg) + 34'(s3_sqy_reg) + 34'(s3_sqz_reg);

    always_ff @(posedge clk)
    begin
        side_sq_reg <= cfg.side_radius * cfg.side_radius;

        s1_rx_reg <= RW'(head_x) - RW'(pose_x_reg);
        s1_ry_reg <= RW'(head_y) - RW'(pose_y_reg);
        s1_rz_reg <= RW'(head_z) - RW'(pose_z_reg);

        s2_cx_reg    <= PW'(heading_cos_reg) * PW'(s1_rx_reg);
        s2_sy_reg    <= PW'(heading_sin_reg) * PW'(s1_ry_reg);
        s2_cy_reg    <= PW'(heading_cos_reg) * PW'(s1_ry_reg);
        s2_sx_reg    <= PW'(heading_sin_reg) * PW'(s1_rx_reg);
        s2_mx_reg    <= s1_rx_reg[RW-1] ? nrx[COORD_WIDTH-1:0] : s1_rx_reg[COORD_WIDTH-1:0];
        s2_my_reg    <= s1_ry_reg[RW-1] ? nry[COORD_WIDTH-1:0] : s1_ry_reg[COORD_WIDTH-1:0];
        s2_mz_reg    <= s1_rz_reg[RW-1] ? nrz[COORD_WIDTH-1:0] : s1_rz_reg[COORD_WIDTH-1:0];
        s2_below_reg <= (s1_rz_reg < -RW'(BELOW_LIMIT));

        // dropping the low bits of two's complement floors the shift
        s3_xf_reg   <= sum_f[PW:14];
        s3_yf_reg   <= sum_l[PW:14];
        s3_sqx_reg  <= s2_mx_reg[15:0] * s2_mx_reg[15:0];
        s3_sqy_reg  <= s2_my_reg[15:0] * s2_my_reg[15:0];
        s3_sqz_reg  <= s2_mz_reg[15:0] * s2_mz_reg[15:0];
        s3_near_reg <= !s2_below_reg
                       && (s2_mx_reg <= COORD_WIDTH'(cfg.side_radius))
                       && (s2_my_reg <= COORD_WIDTH'(cfg.side_radius))
                       && (s2_mz_reg <= COORD_WIDTH'(cfg.side_radius));
        s3_mz_reg   <= s2_mz_reg;

        s4_fprod_reg   <= s3_xf_reg[MW-1:0] * cfg.cone_slope;
        s4_ahead_reg   <= (s3_xf_reg >= XW'(FWD_MIN));
        s4_xf_sat_reg  <= (xf_ext[SW-1:FWD_W] != '0) ? FWD_SAT : xf_ext[FWD_W-1:0];
        s4_yfm_reg     <= s3_yf_reg[XW-1] ? nyf[MW-1:0] : s3_yf_reg[MW-1:0];
        s4_mz_reg      <= s3_mz_reg;
        s4_side_ok_reg <= s3_near_reg && (d2 <= 34'(side_sq_reg));
        s4_d2_reg      <= d2[31:0];

        s5_rmax_reg    <= RMW'(cfg.cone_base_radius) + s4_fprod_reg[FPW-1:12];
        s5_yfm_reg     <= s4_yfm_reg;
        s5_mz_reg      <= s4_mz_reg;
        s5_ahead_reg   <= s4_ahead_reg;
        s5_side_ok_reg <= s4_side_ok_reg;
        s5_xf_sat_reg  <= s4_xf_sat_reg;
        s5_d2_reg      <= s4_d2_reg;

        s6_ahead_reg   <= s5_ahead_reg;
        s6_side_ok_reg <= s5_side_ok_reg;
        s6_xf_sat_reg  <= s5_xf_sat_reg;
        s6_d2_reg      <= s5_d2_reg;

        s7_ahead_reg   <= s6_ahead_reg;
        s7_side_ok_reg <= s6_side_ok_reg;
        s7_xf_sat_reg  <= s6_xf_sat_reg;
        s7_d2_reg      <= s6_d2_reg;
    end

    ocss_square #(.N(MW)) u_sq_lat (
        .clk (clk),
        .a   (s5_yfm_reg),
        .sq  (ysq)
    );

    ocss_square #(.N(COORD_WIDTH)) u_sq_up (
        .clk (clk),
        .a   (s5_mz_reg),
        .sq  (zsq)
    );

    ocss_square #(.N(RMW)) u_sq_cone (
        .clk (clk),
        .a   (s5_rmax_reg),
        .sq  (rsq)
    );

    assign lat     = (2*RMW)'(ysq) + (2*RMW)'(zsq);
    assign cone_ok = s7_ahead_reg && (lat <= rsq);

    // ---- minima ----
    always_comb
    begin
        best_forward_next     = best_forward_reg;
        forward_hit_next      = forward_hit_reg;
        best_side_square_next = best_side_square_reg;
        side_hit_next         = side_hit_reg;
        if (pose_load)
        begin
            best_forward_next     = '1;
            forward_hit_next      = 1'b0;
            best_side_square_next = '1;
            side_hit_next         = 1'b0;
        end
        else if (pipe_v_reg[PIPE_DEPTH-1])
        begin
            if (cone_ok)
            begin
                if (24'(s7_xf_sat_reg) < best_forward_reg)
                    best_forward_next = 24'(s7_xf_sat_reg);
                forward_hit_next = 1'b1;
            end
            if (s7_side_ok_reg)
            begin
                if (s7_d2_reg < best_side_square_reg)
                    best_side_square_next = s7_d2_reg;
                side_hit_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_forward_reg     <= '1;
            forward_hit_reg      <= 1'b0;
            best_side_square_reg <= '1;
            side_hit_reg         <= 1'b0;
        end
        else
        begin
            best_forward_reg     <= best_forward_next;
            forward_hit_reg      <= forward_hit_next;
            best_side_square_reg <= best_side_square_next;
            side_hit_reg         <= side_hit_next;
        end
    end

    // ---- side root and result word ----
    ocss_isqrt u_isqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (sqrt_start),
        .operand (best_side_square_reg),
        .busy    (sqrt_busy),
        .root    (sqrt_root)
    );

    logic              out_valid_reg, out_valid_next;
    logic [FWD_W-1:0]  out_fwd_reg;
    logic              out_ff_reg;
    logic [SIDE_W-1:0] out_side_reg;
    logic              out_sf_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
            out_valid_next = 1'b1;
        else if (result.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    // minima are frozen once the drain has emptied the pipeline until emit, nothing is popped meanwhile
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_fwd_reg  <= forward_hit_reg ? best_forward_reg[FWD_W-1:0] : FWD_SAT;
            out_ff_reg   <= forward_hit_reg;
            out_side_reg <= side_hit_reg ? sqrt_root : SIDE_INF;
            out_sf_reg   <= side_hit_reg;
        end
    end

    assign result.valid            = out_valid_reg;
    assign result.forward_distance = out_fwd_reg;
    assign result.forward_found    = out_ff_reg;
    assign result.side_distance    = out_side_reg;
    assign result.side_found       = out_sf_reg;

endmodule

@@ src/obstacle_cone_sphere_scan.sv @@
// obstacle_cone_sphere_scan: top level, configuration registers, front queue and back pipeline
// depends on ocss_pkg, ocss_if, ocss_front and ocss_back
//
//  channel  modport  words
//  item     sink     pose or point: action, coord_x/y/z, heading_cos/sin, last
//  cfg      sink     register write: index, data (always ready)
//  result   source   forward_distance, forward_found, side_distance, side_found
//
// point words issue one per cycle while the back runs and the queue is not empty, into a
// 7-stage pipeline (rotation, cone and sphere tests, split squarers); a pose word waits
// for the pipeline to drain. a word with last adds the drain, the bit-serial root and the
// load of the result register; a 4-word queue keeps accepting meanwhile until it is full.
// reset loads the default configuration, the reset pose and empty minima; no sweep.
// a stalled result holds in its register while later words still enter the queue.

module obstacle_cone_sphere_scan
    import ocss_pkg::*;
#(
    parameter int COORD_WIDTH = 24
)(
    input  logic       clk,
    input  logic       rst_n,
    ocss_in_if.sink    item,
    ocss_cfg_if.sink   cfg,
    ocss_out_if.source result
);

    cfg_t cfg_set_reg, cfg_set_next;

    logic                          head_valid;
    item_kind_t                    head_kind;
    logic signed [COORD_WIDTH-1:0] head_x, head_y, head_z;
    logic signed [15:0]            head_cos, head_sin;
    logic                          head_pop;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        cfg_set_next = cfg_set_reg;
        if (cfg.valid)
        begin
            case (cfg.index)
                CFG_CONE_BASE:   cfg_set_next.cone_base_radius = cfg.data;
                CFG_CONE_SLOPE:  cfg_set_next.cone_slope       = cfg.data;
                CFG_SIDE_RADIUS: cfg_set_next.side_radius      = cfg.data;
                default:         cfg_set_next = cfg_set_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_set_reg.cone_base_radius <= CONE_BASE_RESET;
            cfg_set_reg.cone_slope       <= CONE_SLOPE_RESET;
            cfg_set_reg.side_radius      <= SIDE_RADIUS_RESET;
        end
        else
        begin
            cfg_set_reg <= cfg_set_next;
        end
    end

    ocss_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (item),
        .head_valid (head_valid),
        .head_kind  (head_kind),
        .head_x     (head_x),
        .head_y     (head_y),
        .head_z     (head_z),
        .head_cos   (head_cos),
        .head_sin   (head_sin),
        .head_pop   (head_pop)
    );

    ocss_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_set_reg),
        .head_valid (head_valid),
        .head_kind  (head_kind),
        .head_x     (head_x),
        .head_y     (head_y),
        .head_z     (head_z),
        .head_cos   (head_cos),
        .head_sin   (head_sin),
        .head_pop   (head_pop),
        .result     (result)
    );

`ifndef NO_ASSERTIONS
    a_fwd_empty: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.forward_found |-> result.forward_distance == FWD_SAT)
        else $error("empty forward result not saturated");

    a_side_empty: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.side_found |-> result.side_distance == SIDE_INF)
        else $error("empty side result not at infinity");

    a_fwd_min: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.forward_found |-> result.forward_distance >= FWD_W'(FWD_MIN))
        else $error("forward hit closer than the minimum depth");

    a_side_radius: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && result.side_found |-> result.side_distance <= cfg_set_reg.side_radius)
        else $error("side hit outside the side radius");
`endif

endmodule
